// File: hdl/trd_pkg.sv
package trd_pkg;

  // Register map, indexed by paddr[3:2].
  typedef enum logic [1:0] {
    REG_SOURCE_PIXEL_BYTES = 2'd0,
    REG_DEST_PIXEL_BYTES   = 2'd1,
    REG_ROW_WIDTH          = 2'd2
  } trd_reg_t;

  localparam logic [2:0]  SOURCE_PIXEL_BYTES_RST = 3'd3;
  localparam logic [2:0]  DEST_PIXEL_BYTES_RST   = 3'd4;
  localparam logic [14:0] ROW_WIDTH_RST          = 15'd1;

  localparam logic [2:0]  PIXEL_BYTES_4 = 3'd4;
  localparam logic [2:0]  PIXEL_BYTES_3 = 3'd3;

  localparam int unsigned HDR_RUN_BIT   = 7;
  localparam logic [31:0] PIXEL_ALL_ONES = 32'hffff_ffff;
  localparam logic [31:0] DEST3_MASK     = 32'h00ff_ffff;

  typedef struct packed {
    logic [2:0]  source_pixel_bytes;
    logic [2:0]  dest_pixel_bytes;
    logic [14:0] row_width;
  } trd_cfg_t;

  // One decoded pixel on its way from the parser to the output stage.
  typedef struct packed {
    logic [31:0] color;
    logic [7:0]  repeat_count;
    logic        row_end;
    logic        overflow;
  } trd_pix_t;

endpackage

// File: hdl/tga_rle_row_decoder_top.sv
// Path: a result is written into the queue at the edge that accepts the beat carrying
// the last byte of its pixel, then loaded into the output register once that is free;
// headers and other bytes give none. Throughput: one byte per cycle while the queue is
// not full; a result can leave every cycle through the output register while pop is held.
// Reset: rst_n is synchronous and active low; it clears the parser, the queue and
// the output valid flag, and loads the registers with 3, 4 and 1.
module tga_rle_row_decoder_top
  import trd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,

  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_color,
  output logic [7:0]  out_repeat_count,
  output logic        out_row_end,
  output logic        out_overflow,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  trd_cfg_t cfg_r;
  trd_reg_t reg_sel;
  logic     cfg_wr;

  logic     byte_valid;
  logic     pix_valid;
  trd_pix_t pix;
  logic     q_full, q_empty, q_rd;
  trd_pix_t q_data;
  trd_pix_t out_pix;

  assign pready  = 1'b1;
  assign reg_sel = trd_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_pixel_bytes <= SOURCE_PIXEL_BYTES_RST;
      cfg_r.dest_pixel_bytes   <= DEST_PIXEL_BYTES_RST;
      cfg_r.row_width          <= ROW_WIDTH_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SOURCE_PIXEL_BYTES: cfg_r.source_pixel_bytes <= pwdata[2:0];
        REG_DEST_PIXEL_BYTES:   cfg_r.dest_pixel_bytes   <= pwdata[2:0];
        REG_ROW_WIDTH:          cfg_r.row_width          <= pwdata[14:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SOURCE_PIXEL_BYTES: prdata = {29'b0, cfg_r.source_pixel_bytes};
      REG_DEST_PIXEL_BYTES:   prdata = {29'b0, cfg_r.dest_pixel_bytes};
      REG_ROW_WIDTH:          prdata = {17'b0, cfg_r.row_width};
      default:                prdata = '0;
    endcase
  end

  assign full       = q_full;
  assign byte_valid = push && !q_full;

  trd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_valid (byte_valid),
    .data_byte  (in_data_byte),
    .pix_valid  (pix_valid),
    .pix        (pix)
  );

  trd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (pix_valid),
    .wr_data (pix),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  trd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .out_pix (out_pix)
  );

  assign out_color        = out_pix.color;
  assign out_repeat_count = out_pix.repeat_count;
  assign out_row_end      = out_pix.row_end;
  assign out_overflow     = out_pix.overflow;

endmodule

// File: hdl/trd_front.sv
module trd_front
  import trd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  trd_cfg_t cfg,
  input  logic     byte_valid,
  input  logic [7:0] data_byte,
  output logic     pix_valid,
  output trd_pix_t pix
);

  logic        expect_header_r, expect_header_nxt;
  logic        packet_is_run_r, packet_is_run_nxt;
  logic [7:0]  pixels_left_r,   pixels_left_nxt;
  logic [1:0]  byte_index_r,    byte_index_nxt;
  logic [31:0] assembly_r,      assembly_nxt;
  logic [14:0] row_position_r,  row_position_nxt;
  logic        clip_r,          clip_nxt;

  logic [14:0] width;
  logic [14:0] hdr_pos;
  logic [14:0] room;
  logic [7:0]  count;
  logic        hdr_clip;
  logic [31:0] merged;
  logic        last_byte;
  logic [7:0]  reps;
  logic [7:0]  left_after;
  logic [15:0] pos_sum;
  logic        row_end;

  always_comb begin
    width    = (cfg.row_width == '0) ? 15'd1 : cfg.row_width;
    // A width change can leave the position beyond the row; restart the row then.
    hdr_pos  = (row_position_r >= width) ? '0 : row_position_r;
    room     = width - hdr_pos;
    count    = {1'b0, data_byte[6:0]} + 8'd1;
    hdr_clip = {8'b0, count} > {1'b0, room};

    merged = assembly_r;
    merged[{byte_index_r, 3'b000} +: 8] = data_byte;

    // A source size switched to 3 mid-pixel can leave the index at 3; that byte ends the pixel.
    last_byte = (cfg.source_pixel_bytes == PIXEL_BYTES_4) ? (byte_index_r == 2'd3)
                                                         : (byte_index_r >= 2'd2);

    if (packet_is_run_r) begin
      reps       = (pixels_left_r == '0) ? 8'd1 : pixels_left_r;
      left_after = '0;
    end else begin
      reps       = 8'd1;
      left_after = (pixels_left_r == '0) ? 8'd0 : pixels_left_r - 8'd1;
    end

    pos_sum = {1'b0, row_position_r} + {8'b0, reps};
    row_end = pos_sum >= {1'b0, width};

    expect_header_nxt = expect_header_r;
    packet_is_run_nxt = packet_is_run_r;
    pixels_left_nxt   = pixels_left_r;
    byte_index_nxt    = byte_index_r;
    assembly_nxt      = assembly_r;
    row_position_nxt  = row_position_r;
    clip_nxt          = clip_r;
    pix_valid         = 1'b0;

    if (byte_valid) begin
      if (expect_header_r) begin
        expect_header_nxt = 1'b0;
        packet_is_run_nxt = data_byte[HDR_RUN_BIT];
        pixels_left_nxt   = hdr_clip ? room[7:0] : count;
        clip_nxt          = hdr_clip;
        byte_index_nxt    = '0;
        assembly_nxt      = PIXEL_ALL_ONES;
        row_position_nxt  = hdr_pos;
      end else if (!last_byte) begin
        byte_index_nxt = byte_index_r + 2'd1;
        assembly_nxt   = merged;
      end else begin
        pix_valid         = 1'b1;
        byte_index_nxt    = '0;
        assembly_nxt      = PIXEL_ALL_ONES;
        pixels_left_nxt   = left_after;
        expect_header_nxt = (left_after == '0);
        row_position_nxt  = row_end ? '0 : pos_sum[14:0];
      end
    end

    pix.color        = merged;
    pix.repeat_count = reps;
    pix.row_end      = row_end;
    pix.overflow     = clip_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_header_r <= 1'b1;
      packet_is_run_r <= 1'b0;
      pixels_left_r   <= '0;
      byte_index_r    <= '0;
      assembly_r      <= PIXEL_ALL_ONES;
      row_position_r  <= '0;
      clip_r          <= 1'b0;
    end else begin
      expect_header_r <= expect_header_nxt;
      packet_is_run_r <= packet_is_run_nxt;
      pixels_left_r   <= pixels_left_nxt;
      byte_index_r    <= byte_index_nxt;
      assembly_r      <= assembly_nxt;
      row_position_r  <= row_position_nxt;
      clip_r          <= clip_nxt;
    end
  end

endmodule

// File: hdl/trd_queue.sv
module trd_queue
  import trd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  trd_pix_t wr_data,
  input  logic     rd_en,
  output trd_pix_t rd_data,
  output logic     full,
  output logic     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  trd_pix_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    full    = (cnt_r == CW'(DEPTH));
    empty   = (cnt_r == '0);
    rd_data = mem_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full) else $error("queue written while full");

  a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty) else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count beyond depth");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a write");
`endif

endmodule

// File: hdl/trd_back.sv
module trd_back
  import trd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  trd_cfg_t cfg,
  input  logic     q_empty,
  input  trd_pix_t q_data,
  output logic     q_rd,
  input  logic     pop,
  output logic     empty,
  output trd_pix_t out_pix
);

  logic     out_valid_r, out_valid_nxt;
  trd_pix_t out_pix_r,   out_pix_nxt;

  always_comb begin
    q_rd          = !q_empty && (!out_valid_r || pop);
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    if (q_rd) begin
      out_valid_nxt = 1'b1;
      out_pix_nxt   = q_data;
      // A 3-byte destination drops the top byte of the assembled pixel.
      if (cfg.dest_pixel_bytes == PIXEL_BYTES_3) begin
        out_pix_nxt.color = q_data.color & DEST3_MASK;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_pix_r <= out_pix_nxt;
  end

  assign empty   = !out_valid_r;
  assign out_pix = out_pix_r;

endmodule
